/* design/ffba_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared sizes, codes, state type and controller/datapath links of the
// first-fit bin allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

   localparam int NUM_BINS   = 1024;
   localparam int BLOCK_SIZE = 32;
   localparam int NUM_BLOCKS = (NUM_BINS + BLOCK_SIZE - 1) / BLOCK_SIZE;

   localparam int ADDR_W     = $clog2(NUM_BINS);
   localparam int POS_W      = $clog2(BLOCK_SIZE);
   localparam int BLK_W      = $clog2(NUM_BLOCKS);
   localparam int CNT_W      = 11;
   localparam int ROOM_W     = 31;
   localparam int INDEX_W    = 10;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 16;
   localparam int CSR_IDX_W  = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_BIN_COUNT    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BIN_CAPACITY = 1'd1;

   localparam logic ACT_REFILL   = 1'b0;
   localparam logic ACT_ALLOCATE = 1'b1;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_FILL,
      S_BLK,
      S_BIN,
      S_DRAIN,
      S_CHECK,
      S_DONE
   } ffba_state_type;

   typedef struct packed {
      logic load;
      logic clr;
      logic fill_wr;
      logic fill_zero;
      logic fill_blkmax;
      logic blk_inc;
      logic bin_start;
      logic bin_issue;
      logic commit;
      logic rsp_load;
   } ffba_cmd_type;

   typedef struct packed {
      logic is_alloc;
      logic blk_past;
      logic blk_fits;
      logic blk_last;
      logic pos_last;
      logic sweep_last;
      logic found;
      logic out_free;
   } ffba_stat_type;

endpackage
`default_nettype wire

/* design/ffba_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_datapath
// Bin room memory, block maxima, sweep and scan counters, fit test and
// result register.
// ----------------------------------------------------------------------------
module ffba_datapath (
   input  wire                                   clock,
   input  wire                                   reset,
   input  ffba_pkg::ffba_cmd_type                cmd_i,
   output ffba_pkg::ffba_stat_type               stat_o,
   input  wire  [ffba_pkg::REQ_DATA_W-1:0]       req_tdata,
   input  wire                                   req_tuser,
   input  wire                                   csr_we,
   input  wire  [ffba_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire  [ffba_pkg::ROOM_W-1:0]           csr_wdata,
   output logic                                  rsp_tvalid,
   input  wire                                   rsp_tready,
   output logic [ffba_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   output logic                                  rsp_tuser
);
   import ffba_pkg::*;

   logic [CNT_W-1:0]   bin_count_ff;
   logic [ROOM_W-1:0]  cap_ff;
   logic [ROOM_W-1:0]  req_size_ff;
   logic               action_ff;
   logic [BLK_W-1:0]   blk_ff;
   logic [POS_W-1:0]   pos_ff;
   logic [POS_W-1:0]   d_pos_ff;
   logic               d_valid_ff;
   logic [ROOM_W-1:0]  rdata_ff;
   logic [ROOM_W-1:0]  max_acc_ff;
   logic [ROOM_W-1:0]  new_val_ff;
   logic               found_ff;
   logic [ADDR_W-1:0]  found_idx_ff;
   logic               rsp_valid_ff;
   logic               rsp_found_ff;
   logic [INDEX_W-1:0] rsp_index_ff;
   logic [ROOM_W-1:0]  bin_mem [NUM_BINS];
   logic [ROOM_W-1:0]  blkmax_ff [NUM_BLOCKS];

   logic [CNT_W-1:0]   act;
   logic [ADDR_W-1:0]  sweep_addr;
   logic [ADDR_W-1:0]  sweep_addr_in;
   logic [ADDR_W-1:0]  d_idx;
   logic [ROOM_W-1:0]  fill_val;
   logic [ROOM_W-1:0]  diff;
   logic [ROOM_W-1:0]  cand;
   logic               d_active;
   logic               fit;

   always_comb begin
      act           = (bin_count_ff > CNT_W'(NUM_BINS)) ? CNT_W'(NUM_BINS) : bin_count_ff;
      sweep_addr    = {blk_ff, pos_ff};
      sweep_addr_in = sweep_addr + ADDR_W'(1);
      d_idx         = {blk_ff, d_pos_ff};
      fill_val      = (!cmd_i.fill_zero && (CNT_W'(sweep_addr) < act)) ? cap_ff : '0;
      diff          = rdata_ff - req_size_ff;
      d_active      = CNT_W'(d_idx) < act;
      fit           = d_valid_ff && d_active && !found_ff && (rdata_ff >= req_size_ff);
      cand          = fit ? diff : rdata_ff;
   end

   // bin room memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (cmd_i.fill_wr) begin
         bin_mem[sweep_addr] <= fill_val;
      end else if (cmd_i.commit) begin
         bin_mem[found_idx_ff] <= new_val_ff;
      end
      rdata_ff <= bin_mem[sweep_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_count_ff <= CNT_W'(NUM_BINS);
         cap_ff       <= '0;
         blk_ff       <= '0;
         pos_ff       <= '0;
         d_valid_ff   <= 1'b0;
         found_ff     <= 1'b0;
         found_idx_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int b = 0; b < NUM_BLOCKS; b++) begin
            blkmax_ff[b] <= '0;
         end
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_BIN_COUNT:    bin_count_ff <= csr_wdata[CNT_W-1:0];
               CSR_BIN_CAPACITY: cap_ff       <= csr_wdata;
               default: begin
               end
            endcase
         end

         if (cmd_i.clr) begin
            blk_ff <= '0;
            pos_ff <= '0;
         end else if (cmd_i.fill_wr) begin
            {blk_ff, pos_ff} <= sweep_addr_in;
         end else begin
            if (cmd_i.blk_inc) begin
               blk_ff <= blk_ff + BLK_W'(1);
            end
            if (cmd_i.bin_issue) begin
               pos_ff <= pos_ff + POS_W'(1);
            end
         end

         d_valid_ff <= cmd_i.bin_issue;

         if (cmd_i.clr) begin
            found_ff     <= 1'b0;
            found_idx_ff <= '0;
         end else if (fit) begin
            found_ff     <= 1'b1;
            found_idx_ff <= d_idx;
         end

         if (cmd_i.fill_blkmax) begin
            for (int b = 0; b < NUM_BLOCKS; b++) begin
               blkmax_ff[b] <= (CNT_W'(b * BLOCK_SIZE) < act) ? cap_ff : '0;
            end
         end else if (cmd_i.commit) begin
            blkmax_ff[blk_ff] <= max_acc_ff;
         end

         if (cmd_i.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      d_pos_ff <= pos_ff;
      if (cmd_i.load) begin
         req_size_ff <= req_tdata[ROOM_W-1:0];
         action_ff   <= req_tuser;
      end
      if (cmd_i.bin_start) begin
         max_acc_ff <= '0;
      end else if (d_valid_ff && (cand > max_acc_ff)) begin
         max_acc_ff <= cand;
      end
      if (fit) begin
         new_val_ff <= diff;
      end
      if (cmd_i.rsp_load) begin
         rsp_found_ff <= found_ff;
         rsp_index_ff <= found_idx_ff[INDEX_W-1:0];
      end
   end

   always_comb begin
      stat_o.is_alloc   = action_ff == ACT_ALLOCATE;
      stat_o.blk_past   = CNT_W'({blk_ff, {POS_W{1'b0}}}) >= act;
      stat_o.blk_fits   = blkmax_ff[blk_ff] >= req_size_ff;
      stat_o.blk_last   = blk_ff == BLK_W'(NUM_BLOCKS - 1);
      stat_o.pos_last   = pos_ff == POS_W'(BLOCK_SIZE - 1);
      stat_o.sweep_last = sweep_addr == ADDR_W'(NUM_BINS - 1);
      stat_o.found      = found_ff;
      stat_o.out_free   = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - INDEX_W){1'b0}}, rsp_index_ff};
   assign rsp_tuser  = rsp_found_ff;

   a_commit_found: assert property (@(posedge clock) disable iff (reset)
      cmd_i.commit |-> found_ff)
      else $error("commit without a fitting bin");

   a_fit_in_block: assert property (@(posedge clock) disable iff (reset)
      fit |-> (blkmax_ff[blk_ff] >= req_size_ff))
      else $error("bin fits but its block maximum is too small");

   a_rebuild_covers: assert property (@(posedge clock) disable iff (reset)
      cmd_i.commit |-> (max_acc_ff >= new_val_ff))
      else $error("rebuilt block maximum below the updated bin");

endmodule
`default_nettype wire

/* design/ffba_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_ctrl
// Sequencer for clear, refill sweep, block scan, bin scan and commit.
// ----------------------------------------------------------------------------
module ffba_ctrl (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_tvalid,
   output logic                     req_tready,
   input  wire                      req_tuser,
   input  ffba_pkg::ffba_stat_type  stat_i,
   output ffba_pkg::ffba_cmd_type   cmd_o
);
   import ffba_pkg::*;

   ffba_state_type state_ff;
   ffba_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd_o      = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd_o.fill_wr   = 1'b1;
            cmd_o.fill_zero = 1'b1;
            if (stat_i.sweep_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd_o.load = 1'b1;
               cmd_o.clr  = 1'b1;
               state_in   = (req_tuser == ACT_ALLOCATE) ? S_BLK : S_FILL;
            end
         end
         S_FILL: begin
            cmd_o.fill_wr = 1'b1;
            if (stat_i.sweep_last) begin
               cmd_o.fill_blkmax = 1'b1;
               state_in          = S_DONE;
            end
         end
         S_BLK: begin
            if (stat_i.blk_past) begin
               state_in = S_DONE;
            end else if (stat_i.blk_fits) begin
               cmd_o.bin_start = 1'b1;
               state_in        = S_BIN;
            end else if (stat_i.blk_last) begin
               state_in = S_DONE;
            end else begin
               cmd_o.blk_inc = 1'b1;
            end
         end
         S_BIN: begin
            cmd_o.bin_issue = 1'b1;
            if (stat_i.pos_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (stat_i.found) begin
               cmd_o.commit = 1'b1;
               state_in     = S_DONE;
            end else if (stat_i.blk_last) begin
               state_in = S_DONE;
            end else begin
               cmd_o.blk_inc = 1'b1;
               state_in      = S_BLK;
            end
         end
         S_DONE: begin
            if (stat_i.out_free) begin
               cmd_o.rsp_load = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   a_commit_only_alloc: assert property (@(posedge clock) disable iff (reset)
      cmd_o.commit |-> stat_i.is_alloc)
      else $error("commit on a refill request");

   a_scan_after_fit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BLK && state_in == S_BIN) |-> (stat_i.blk_fits && !stat_i.blk_past))
      else $error("bin scan entered on a block that cannot fit");

   a_done_then_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_o.rsp_load |=> state_ff == S_IDLE)
      else $error("result loaded without returning to idle");

endmodule
`default_nettype wire

/* design/first_fit_bin_allocator_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_bin_allocator_core
// First-fit allocator over 1024 bins in blocks of 32, with block maxima to
// skip blocks that cannot hold a request.
// ----------------------------------------------------------------------------
//  channel | dir | handshake             | payload
//  req_    | in  | req_tvalid/req_tready | tuser: action, tdata: request_size
//  rsp_    | out | rsp_tvalid/rsp_tready | tuser: found,  tdata: bin_index
//  csr_    | in  | csr_we                | csr_index, csr_wdata
//
//  Allocate: accept, a block-maximum walk over up to 32 blocks, one bin scan
//  per fitting block (32 memory reads, drain, commit) and a result load.
//  Refill: accept, 1024 bin memory writes (one per cycle), result.
//  Reset starts a clearing pass over all 1024 bins of the bin memory; no
//  request is taken during it. A waiting result holds in the output
//  register while the next request is taken; finishing stalls only while
//  that register is full.
// ----------------------------------------------------------------------------
module first_fit_bin_allocator_core (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   input  wire  [ffba_pkg::REQ_DATA_W-1:0]      req_tdata,  // [30:0] request_size
   input  wire                                  req_tuser,  // [0] action
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   output logic [ffba_pkg::RSP_DATA_W-1:0]      rsp_tdata,  // [9:0] bin_index
   output logic                                 rsp_tuser,  // [0] found
   input  wire                                  csr_we,
   input  wire  [ffba_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire  [ffba_pkg::ROOM_W-1:0]          csr_wdata
);
   import ffba_pkg::*;

   ffba_cmd_type  cmd;
   ffba_stat_type stat;

   ffba_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .stat_i     (stat),
      .cmd_o      (cmd)
   );

   ffba_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd_i      (cmd),
      .stat_o     (stat),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
`default_nettype wire
